/* sv/gpp_pkg.sv */
// Shared constants, types and helpers of the prime pair finder.
package gpp_pkg;

  localparam int VAL_W     = 20;
  localparam int MAX_VALUE = 1048576;
  localparam int MAP_AW    = $clog2(MAX_VALUE);
  localparam int CNT_W     = MAP_AW + 1;
  localparam int ROOT_W    = (MAP_AW + 1) / 2 + 1;
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int EXT_W     = ((VAL_W > CNT_W) ? VAL_W : CNT_W) + 1;

  localparam int FIRST_PRIME = 2;
  localparam int FIRST_ODD   = 3;
  localparam int ODD_STEP    = 2;

  typedef struct packed {
    logic clr_step;
    logic sieve_init;
    logic sq_load;
    logic rd_sieve;
    logic i_inc;
    logic mark_load;
    logic mark_step;
    logic query_load;
    logic probe_latch;
    logic p_step;
    logic res_found;
    logic res_none;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sq_big;
    logic i_comp;
    logic mark_last;
    logic probe_out;
    logic pair_ok;
  } dp_status_t;

  function automatic logic in_map(input logic [VAL_W-1:0] v);
    return EXT_W'(v) < EXT_W'(MAX_VALUE);
  endfunction

  function automatic logic [MAP_AW-1:0] map_addr(input logic [VAL_W-1:0] v);
    return MAP_AW'(v);
  endfunction

endpackage

/* sv/gpp_ram.sv */
// Generic RAM: one write port, two registered read ports, no reset.
module gpp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* sv/gpp_ctrl.sv */
// Controller: sieve build sequence after reset, then the candidate search.
module gpp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  gpp_pkg::dp_status_t status_i,
  output gpp_pkg::dp_cmd_t    cmd_o,
  output logic                busy_o
);
  import gpp_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_SQ    = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_MARK  = 7'b0001000,
    S_IDLE  = 7'b0010000,
    S_PROBE = 7'b0100000,
    S_EVAL  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          cmd_o.sieve_init = 1'b1;
          state_d          = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_load  = 1'b1;
        cmd_o.rd_sieve = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.sq_big) begin
          state_d = S_IDLE;
        end else if (status_i.i_comp) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_SQ;
        end else begin
          cmd_o.mark_load = 1'b1;
          state_d         = S_MARK;
        end
      end
      S_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (status_i.mark_last) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_SQ;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.query_load = 1'b1;
          state_d          = S_PROBE;
        end
      end
      S_PROBE: begin
        if (status_i.probe_out) begin
          cmd_o.res_none = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.probe_latch = 1'b1;
          state_d           = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status_i.pair_ok) begin
          cmd_o.res_found = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.p_step = 1'b1;
          state_d      = S_PROBE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* sv/gpp_dpath.sv */
// Datapath: composite map, sieve counters, candidate registers and result.
module gpp_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gpp_pkg::dp_cmd_t         cmd_i,
  output gpp_pkg::dp_status_t      status_o,
  input  logic [gpp_pkg::VAL_W-1:0] query_value_i,
  output logic                     result_valid_o,
  output logic                     pair_found_o,
  output logic [gpp_pkg::VAL_W-1:0] small_prime_o,
  output logic [gpp_pkg::VAL_W-1:0] large_prime_o
);
  import gpp_pkg::*;

  logic [CNT_W-1:0]  j_q, j_d;
  logic [ROOT_W-1:0] i_q;
  logic [SQ_W-1:0]   sq_q;
  logic [VAL_W-1:0]  n_q, p_q, rest_q;
  logic              rng_a_q, rng_b_q;
  logic              valid_q, found_q;
  logic [VAL_W-1:0]  small_q, large_q;

  logic [VAL_W-1:0]  limit;
  logic [VAL_W-1:0]  rest;
  logic [CNT_W-1:0]  j_next_mark;
  logic              we;
  logic              wdata;
  logic [MAP_AW-1:0] raddr_a;
  logic              rd_a, rd_b;

  assign limit       = VAL_W'(n_q >> 1) + VAL_W'(1);
  assign rest        = n_q - p_q;
  assign j_next_mark = j_q + CNT_W'(i_q);

  // clear pass writes the final bit for 0 and 1 directly
  assign we      = cmd_i.clr_step | cmd_i.mark_step;
  assign wdata   = cmd_i.clr_step ? (j_q < CNT_W'(FIRST_PRIME)) : 1'b1;
  assign raddr_a = cmd_i.rd_sieve ? MAP_AW'(i_q) : map_addr(p_q);

  gpp_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VALUE)
  ) u_map (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (j_q[MAP_AW-1:0]),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (map_addr(rest)),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    j_d = j_q;
    if (cmd_i.clr_step) begin
      j_d = j_q + CNT_W'(1);
    end else if (cmd_i.mark_load) begin
      j_d = CNT_W'(sq_q);
    end else if (cmd_i.mark_step) begin
      j_d = j_next_mark;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      j_q     <= j_d;
      valid_q <= cmd_i.res_found | cmd_i.res_none;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sieve_init) begin
      i_q <= ROOT_W'(FIRST_PRIME);
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + ROOT_W'(1);
    end
    if (cmd_i.sq_load) begin
      sq_q <= SQ_W'(i_q) * SQ_W'(i_q);
    end
    if (cmd_i.query_load) begin
      n_q <= query_value_i;
      p_q <= VAL_W'(FIRST_ODD);
    end else if (cmd_i.p_step) begin
      p_q <= p_q + VAL_W'(ODD_STEP);
    end
    if (cmd_i.probe_latch) begin
      rng_a_q <= in_map(p_q);
      rng_b_q <= in_map(rest);
      rest_q  <= rest;
    end
    if (cmd_i.res_found) begin
      found_q <= 1'b1;
      small_q <= p_q;
      large_q <= rest_q;
    end else if (cmd_i.res_none) begin
      found_q <= 1'b0;
      small_q <= '0;
      large_q <= '0;
    end
  end

  assign status_o.clr_last  = (j_q == CNT_W'(MAX_VALUE - 1));
  assign status_o.sq_big    = (sq_q >= SQ_W'(MAX_VALUE));
  assign status_o.i_comp    = rd_a;
  assign status_o.mark_last = (j_next_mark >= CNT_W'(MAX_VALUE));
  assign status_o.probe_out = (p_q > limit) || (p_q > n_q);
  assign status_o.pair_ok   = rng_a_q & rng_b_q & ~rd_a & ~rd_b;

  assign result_valid_o = valid_q;
  assign pair_found_o   = found_q;
  assign small_prime_o  = small_q;
  assign large_prime_o  = large_q;

endmodule

/* sv/goldbach_prime_pair_finder.sv */
// Top level of the prime pair finder: controller, datapath and checks.
// After reset the block builds its composite map by a sieve and holds busy_o
// high throughout: a clearing pass that writes one map bit a cycle over all
// MAX_VALUE addresses, then a check of each sieve base up to the square root
// of MAX_VALUE, marking the multiples of each prime base from its square
// upward. A query is then taken when start_i is high and busy_o low; the
// search tries odd candidates from 3 upward, each in a probe state that reads
// the map at p and n-p through the two read ports, then an eval state that
// judges them. result_valid_o flags each result for exactly one cycle; the
// result outputs hold until the next result, and the receiver cannot hold
// a result off.
module goldbach_prime_pair_finder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [gpp_pkg::VAL_W-1:0] query_value_i,
  output logic                      result_valid_o,
  output logic                      pair_found_o,
  output logic [gpp_pkg::VAL_W-1:0] small_prime_o,
  output logic [gpp_pkg::VAL_W-1:0] large_prime_o
);
  import gpp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gpp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  gpp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .query_value_i  (query_value_i),
    .result_valid_o (result_valid_o),
    .pair_found_o   (pair_found_o),
    .small_prime_o  (small_prime_o),
    .large_prime_o  (large_prime_o)
  );

  // a result only closes a transaction that was being worked on
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result strobe without a search in progress");

  // the map is only written during the build, never once queries are taken
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.clr_step || cmd.mark_step) |-> busy_o)
    else $error("map write outside the sieve build");

  a_found_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && pair_found_o) |->
      (small_prime_o[0] == 1'b1) && (small_prime_o >= VAL_W'(FIRST_ODD)))
    else $error("reported small prime is not an odd value of at least three");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !pair_found_o) |->
      (small_prime_o == '0) && (large_prime_o == '0))
    else $error("not-found result carries non-zero primes");

endmodule
